// File: sv/register_vm_instruction_executor_core_macros.svh
// Assertion macros for the register VM executor checker.
// Included by the checker file only.
`ifndef REGISTER_VM_INSTRUCTION_EXECUTOR_CORE_MACROS_SVH
`define REGISTER_VM_INSTRUCTION_EXECUTOR_CORE_MACROS_SVH
`define RVM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define RVM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: sv/rvm_pkg.sv
// Shared types and constants for the register VM executor.
// No dependencies.
package rvm_pkg;
    localparam logic [3:0] OP_LDI  = 4'd0;
    localparam logic [3:0] OP_ADD  = 4'd1;
    localparam logic [3:0] OP_SUB  = 4'd2;
    localparam logic [3:0] OP_DIV  = 4'd3;
    localparam logic [3:0] OP_MUL  = 4'd4;
    localparam logic [3:0] OP_MOV  = 4'd5;
    localparam logic [3:0] OP_DONE = 4'd6;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DONE     = 2'd1;
    localparam logic [1:0] ST_BAD_OP   = 2'd2;
    localparam logic [1:0] ST_DIV_ZERO = 2'd3;

    localparam int unsigned WORD_W   = 16;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned RESULT_W = 64;

    // Decoded instruction passed from front to back.
    typedef struct packed {
        logic [3:0] opcode;
        logic [3:0] ra;
        logic [3:0] rb;
        logic [3:0] rd;
        logic [7:0] imm;
        logic       bad_op;
    } t_dec;
endpackage

// File: sv/rvm_if.sv
// Valid/ready channel interfaces for the register VM executor.
// Depends on rvm_pkg.
interface rvm_in_if import rvm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] instruction_word;
    modport source (output valid, output instruction_word, input ready);
    modport sink   (input valid, input instruction_word, output ready);
endinterface

interface rvm_out_if import rvm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [RESULT_W-1:0] result_value;
    modport source (output valid, output status, output result_value, input ready);
    modport sink   (input valid, input status, input result_value, output ready);
endinterface

// File: sv/register_vm_instruction_executor_core.sv
// Register VM instruction executor: one 16-bit instruction in, one status and
// result register value out.
//
// Input channel in_ch carries instruction_word; output channel out_ch carries
// status and result_value, both valid/ready, a transfer on valid && ready.
// A two-entry decode queue separates the front from the execute back end.
// Load, add, subtract, move, done and error words sustain one transfer a cycle
// in the back end while the receiver takes results; multiply runs operand load,
// eight 8-bit partial-product steps and writeback; divide waits on the radix-2
// divider, which produces one quotient bit a cycle.
// For these words the accepted word sits in the decode queue and the result in
// the output register, so result valid is registered after the input transfer.
// Done, unknown opcode and divide by zero report the current result register
// and then clear every register. Reset clears the machine through per-register
// valid bits, so the block accepts items right after reset.
// When the receiver stalls the output register holds, the back end stops at
// its next result and the queue fills, then ready drops.
module register_vm_instruction_executor_core import rvm_pkg::*; #(
    parameter int unsigned REG_COUNT  = 16,
    parameter int unsigned DATA_WIDTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rvm_in_if.sink    in_ch,
    rvm_out_if.source out_ch
);
    t_dec dec;
    logic dec_valid, dec_pop;

    rvm_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch),
        .o_dec(dec), .o_dec_valid(dec_valid), .i_dec_pop(dec_pop)
    );

    rvm_back #(.REG_COUNT(REG_COUNT), .DATA_WIDTH(DATA_WIDTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_dec(dec), .i_dec_valid(dec_valid),
        .o_dec_pop(dec_pop), .out_ch(out_ch)
    );
endmodule

// File: sv/rvm_front.sv
// Front end: accepts instruction words, decodes them, and feeds a two-entry queue.
// Depends on rvm_pkg and rvm_if.
module rvm_front import rvm_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rvm_in_if.sink       in_ch,
    output t_dec         o_dec,
    output logic         o_dec_valid,
    input  logic         i_dec_pop
);
    t_dec       r_q [2];
    logic [1:0] r_cnt, n_cnt;
    logic       r_head, r_tail;
    logic       push;
    t_dec       dec;

    always_comb begin
        dec.opcode = in_ch.instruction_word[15:12];
        dec.ra     = in_ch.instruction_word[11:8];
        dec.rb     = in_ch.instruction_word[7:4];
        dec.rd     = in_ch.instruction_word[3:0];
        dec.imm    = in_ch.instruction_word[7:0];
        dec.bad_op = (in_ch.instruction_word[15:12] > OP_DONE);
    end

    assign in_ch.ready = (r_cnt != 2'd2);
    assign push        = in_ch.valid && in_ch.ready;
    assign o_dec_valid = (r_cnt != 2'd0);
    assign o_dec       = r_q[r_head];

    always_comb begin
        n_cnt = r_cnt + {1'b0, push} - {1'b0, i_dec_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_head <= 1'b0;
            r_tail <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (push) r_tail <= ~r_tail;
            if (i_dec_pop) r_head <= ~r_head;
        end
        if (push) r_q[r_tail] <= dec;
    end
endmodule

// File: sv/rvm_divider.sv
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// Depends on nothing.
module rvm_divider #(
    parameter int unsigned W = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_done,
    output logic [W-1:0] o_quo
);
    localparam int unsigned CW = $clog2(W + 1);
    logic [W-1:0]  r_quo, r_den;
    logic [W-1:0]  r_rem;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [W:0]    shifted;
    logic [W:0]    diff;

    assign shifted = {r_rem, r_quo[W-1]};
    assign diff    = shifted - {1'b0, r_den};
    assign o_quo   = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_quo <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            if (!diff[W]) begin
                r_rem <= diff[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= shifted[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end
    end
endmodule

// File: sv/rvm_back.sv
// Back end: register file, execute sequencer and output register.
// Depends on rvm_pkg, rvm_if and rvm_divider.
module rvm_back import rvm_pkg::*; #(
    parameter int unsigned REG_COUNT  = 16,
    parameter int unsigned DATA_WIDTH = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dec     i_dec,
    input  logic     i_dec_valid,
    output logic     o_dec_pop,
    rvm_out_if.source out_ch
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam int unsigned RW = $clog2(REG_COUNT);
    localparam int unsigned MSTEPS = (DATA_WIDTH + 7) / 8;
    localparam int unsigned MCW = $clog2(MSTEPS + 1);

    logic [DATA_WIDTH-1:0] r_rf [REG_COUNT];
    logic [DATA_WIDTH-1:0] r_res;
    logic [REG_COUNT-1:0]  r_vld;
    logic [1:0]            r_state;
    logic [DATA_WIDTH-1:0] r_prod;
    logic [DATA_WIDTH-1:0] r_ma, r_mb;
    logic [MCW-1:0]        r_mcnt;
    logic [RW-1:0]         r_rd;
    logic                  r_ov;
    logic [STATUS_W-1:0]   r_st;
    logic [RESULT_W-1:0]   r_val;

    logic [DATA_WIDTH-1:0] va, vb;
    logic                  can_go, start_div, div_done;
    logic [DATA_WIDTH-1:0] quo;
    logic                  wr_en, clr, emit;
    logic [RW-1:0]         wr_idx;
    logic [DATA_WIDTH-1:0] wr_val, new_res;
    logic [STATUS_W-1:0]   emit_st;
    logic [DATA_WIDTH+7:0] part;

    assign va = r_vld[i_dec.ra[RW-1:0]] ? r_rf[i_dec.ra[RW-1:0]] : '0;
    assign vb = r_vld[i_dec.rb[RW-1:0]] ? r_rf[i_dec.rb[RW-1:0]] : '0;
    // room in output register: empty or draining this cycle
    assign can_go = (r_state == S_IDLE) && i_dec_valid && (!r_ov || out_ch.ready);
    assign start_div = can_go && !i_dec.bad_op && (i_dec.opcode == OP_DIV) && (vb != '0);
    // multiplicand times the next 8 multiplier bits
    assign part = {8'd0, r_ma} * {{DATA_WIDTH{1'b0}}, r_mb[7:0]};

    rvm_divider #(.W(DATA_WIDTH)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start_div),
        .i_num(va), .i_den(vb), .o_done(div_done), .o_quo(quo)
    );

    always_comb begin
        wr_en = 1'b0; wr_idx = i_dec.rd[RW-1:0]; wr_val = '0;
        clr = 1'b0; emit = 1'b0; emit_st = ST_OK; new_res = r_res;
        o_dec_pop = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (can_go) begin
                    case (i_dec.opcode)
                        OP_LDI: begin
                            wr_en = 1'b1; wr_idx = i_dec.ra[RW-1:0];
                            wr_val = DATA_WIDTH'(i_dec.imm);
                            emit = 1'b1; o_dec_pop = 1'b1;
                        end
                        OP_ADD: begin
                            wr_en = 1'b1; wr_val = va + vb; emit = 1'b1; o_dec_pop = 1'b1;
                        end
                        OP_SUB: begin
                            wr_en = 1'b1; wr_val = va - vb; emit = 1'b1; o_dec_pop = 1'b1;
                        end
                        OP_DIV: begin
                            if (vb == '0) begin
                                emit = 1'b1; emit_st = ST_DIV_ZERO; clr = 1'b1;
                                o_dec_pop = 1'b1;
                            end
                        end
                        OP_MUL: ;
                        OP_MOV: begin
                            new_res = va; emit = 1'b1; o_dec_pop = 1'b1;
                        end
                        OP_DONE: begin
                            emit = 1'b1; emit_st = ST_DONE; clr = 1'b1; o_dec_pop = 1'b1;
                        end
                        default: begin
                            emit = 1'b1; emit_st = ST_BAD_OP; clr = 1'b1; o_dec_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_MUL: begin
                if (r_mcnt == '0 && (!r_ov || out_ch.ready)) begin
                    wr_en = 1'b1; wr_idx = r_rd; wr_val = r_prod; emit = 1'b1;
                    o_dec_pop = 1'b1;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    wr_en = 1'b1; wr_idx = r_rd; wr_val = quo; emit = 1'b1;
                    o_dec_pop = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vld   <= '0;
            r_ov    <= 1'b0;
            r_res   <= '0;
        end else begin
            if (emit) r_ov <= 1'b1;
            else if (out_ch.ready) r_ov <= 1'b0;
            if (clr) begin
                r_vld <= '0;
                r_res <= '0;
            end else begin
                r_res <= new_res;
                if (wr_en) r_vld[wr_idx] <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (can_go && i_dec.opcode == OP_MUL) r_state <= S_MUL;
                    else if (start_div) r_state <= S_DIV;
                end
                S_MUL: if (o_dec_pop) r_state <= S_IDLE;
                S_DIV: if (div_done) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
        if (wr_en && !clr) r_rf[wr_idx] <= wr_val;
        if (can_go) begin
            r_rd   <= i_dec.rd[RW-1:0];
            r_ma   <= va;
            r_mb   <= vb;
            r_prod <= '0;
            r_mcnt <= MCW'(MSTEPS);
        end else if (r_state == S_MUL && r_mcnt != '0) begin
            // accumulate one 8-bit slice of the multiplier per cycle
            r_prod <= r_prod + part[DATA_WIDTH-1:0];
            r_ma   <= r_ma << 8;
            r_mb   <= r_mb >> 8;
            r_mcnt <= r_mcnt - MCW'(1);
        end
        if (emit) begin
            r_st  <= emit_st;
            r_val <= RESULT_W'(new_res);
        end
    end

    assign out_ch.valid        = r_ov;
    assign out_ch.status       = r_st;
    assign out_ch.result_value = r_val;
endmodule

// File: sv/rvm_checker.sv
// Port-level checker for the register VM executor, bound to the top level.
// Depends on rvm_pkg and the macros header.
`include "register_vm_instruction_executor_core_macros.svh"
module rvm_checker import rvm_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [STATUS_W-1:0] out_status,
    input logic [RESULT_W-1:0] out_value
);
    logic [2:0] r_inflight, n_inflight;
    logic       r_after_err;
    logic       in_xfer, out_xfer;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    always_comb begin
        n_inflight = r_inflight + {2'd0, in_xfer} - {2'd0, out_xfer};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight  <= 3'd0;
            r_after_err <= 1'b0;
        end else begin
            r_inflight <= n_inflight;
            // remember whether the last result ended a program
            if (out_xfer) r_after_err <= (out_status != ST_OK);
        end
    end

    `RVM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_value), "output changed while stalled")
    `RVM_ASSERT_IMPL(a_value_after_clear, i_clk, i_rst_n, out_valid && r_after_err, out_value == '0, "result register not cleared after done or error")
    `RVM_ASSERT_IMPL(a_out_has_source, i_clk, i_rst_n, out_valid, r_inflight != 3'd0, "result without an accepted instruction")
    `RVM_ASSERT_IMPL(a_ready_when_empty, i_clk, i_rst_n, r_inflight == 3'd0, in_ready, "input not ready while empty")
endmodule

bind register_vm_instruction_executor_core rvm_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_status(out_ch.status), .out_value(out_ch.result_value)
);

// File: bench/register_vm_instruction_executor_core_tb.sv
// Testbench for the register VM instruction executor core.
// Drives instruction words over rvm_in_if, predicts status and result register
// with its own machine model, checks every rvm_out_if transfer. Needs rvm_pkg, rvm_if.
`timescale 1ns / 100ps

module register_vm_instruction_executor_core_tb;
    import rvm_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [RESULT_W-1:0] value;
    } t_vm_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rvm_in_if  in_ch ();
    rvm_out_if out_ch ();

    register_vm_instruction_executor_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source)
    );

    always #5 i_clk = ~i_clk;

    logic [RESULT_W-1:0] vm_regs [16];
    logic [RESULT_W-1:0] vm_result;
    t_vm_result          pending_results [$];
    int                  mismatches = 0;
    int                  results_seen = 0;
    int                  words_sent = 0;
    int                  done_seen = 0;
    int                  err_seen = 0;
    longint              cycle_count = 0;
    bit                  sink_stall_en = 1'b1;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.instruction_word = '0;
        out_ch.ready = 1'b0;
    end

    function automatic void clear_vm();
        foreach (vm_regs[i]) vm_regs[i] = '0;
        vm_result = '0;
    endfunction

    // Execute one word on the local machine and queue the expected transfer.
    function automatic void execute_word(logic [WORD_W-1:0] w);
        logic [3:0]          op;
        logic [RESULT_W-1:0] va;
        logic [RESULT_W-1:0] vb;
        logic [STATUS_W-1:0] st;
        t_vm_result          r;
        op = w[15:12];
        va = vm_regs[w[11:8]];
        vb = vm_regs[w[7:4]];
        st = ST_OK;
        case (op)
            OP_LDI:  vm_regs[w[11:8]] = {56'd0, w[7:0]};
            OP_ADD:  vm_regs[w[3:0]] = va + vb;
            OP_SUB:  vm_regs[w[3:0]] = va - vb;
            OP_DIV: begin
                if (vb == '0) st = ST_DIV_ZERO;
                else vm_regs[w[3:0]] = va / vb;
            end
            OP_MUL:  vm_regs[w[3:0]] = va * vb;
            OP_MOV:  vm_result = va;
            OP_DONE: st = ST_DONE;
            default: st = ST_BAD_OP;
        endcase
        r.status = st;
        r.value = vm_result;
        pending_results.push_back(r);
        if (st == ST_DONE) done_seen++;
        else if (st != ST_OK) err_seen++;
        if (st != ST_OK) clear_vm();
    endfunction

    task automatic send_word(logic [WORD_W-1:0] w);
        int gap;
        in_ch.valid <= 1'b1;
        in_ch.instruction_word <= w;
        do @(posedge i_clk); while (!in_ch.ready);
        execute_word(w);
        words_sent++;
        // idle after the transfer; hold valid high when there is no gap
        gap = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [WORD_W-1:0] make_word(logic [3:0] op, logic [3:0] a,
                                                   logic [3:0] b, logic [3:0] d);
        return {op, a, b, d};
    endfunction

    // Sink side: stall at random, compare each transfer with the oldest expectation.
    initial begin
        int stall;
        t_vm_result want;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = sink_stall_en ? $urandom_range(0, 9) : 0;
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: status %0d value %h",
                             out_ch.status, out_ch.result_value);
            end else begin
                want = pending_results.pop_front();
                if (out_ch.status !== want.status || out_ch.result_value !== want.value) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected status %0d value %h, got %0d %h",
                                 want.status, want.value, out_ch.status,
                                 out_ch.result_value);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2_000_000) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic test_each_opcode();
        logic [3:0] op;
        send_word(make_word(OP_LDI, 4'd0, 4'hF, 4'hF));
        send_word(make_word(OP_LDI, 4'd1, 4'd0, 4'd7));
        send_word(make_word(OP_ADD, 4'd0, 4'd1, 4'd2));
        send_word(make_word(OP_SUB, 4'd1, 4'd0, 4'd3));
        send_word(make_word(OP_MUL, 4'd3, 4'd3, 4'd4));
        send_word(make_word(OP_MUL, 4'd4, 4'd4, 4'd4));
        send_word(make_word(OP_DIV, 4'd4, 4'd0, 4'd5));
        send_word(make_word(OP_DIV, 4'd3, 4'd1, 4'd3));
        send_word(make_word(OP_MOV, 4'd3, 4'd0, 4'd0));
        send_word(make_word(OP_DONE, 4'd0, 4'd0, 4'd0));
        for (int i = 7; i < 16; i++) begin
            op = 4'(i);
            send_word(make_word(OP_LDI, 4'hF, 4'hF, 4'hF));
            send_word(make_word(OP_MOV, 4'hF, 4'd0, 4'd0));
            send_word(make_word(op, 4'hF, 4'hF, 4'hF));
        end
    endtask

    task automatic test_divide_by_zero();
        send_word(make_word(OP_LDI, 4'd2, 4'd9, 4'd9));
        send_word(make_word(OP_MOV, 4'd2, 4'd0, 4'd0));
        send_word(make_word(OP_DIV, 4'd2, 4'd6, 4'd2));
        send_word(make_word(OP_MOV, 4'd2, 4'd0, 4'd0));
    endtask

    task automatic test_random_programs();
        logic [WORD_W-1:0] w;
        int                len;
        while (words_sent < 2000) begin
            len = $urandom_range(3, 30);
            for (int k = 0; k < len; k++) begin
                w = WORD_W'($urandom);
                // Mostly legal opcodes, loads favored early to seed registers.
                if ($urandom_range(0, 19) != 0) begin
                    w[15:12] = (k < 4) ? OP_LDI : 4'($urandom_range(0, 5));
                    // Keep divides rare, each one runs the full bit-serial divider.
                    if (w[15:12] == OP_DIV && $urandom_range(0, 2) != 0) w[15:12] = OP_ADD;
                end
                send_word(w);
            end
            if ($urandom_range(0, 1))
                send_word(make_word(OP_DONE, 4'($urandom), 4'($urandom), 4'($urandom)));
        end
    endtask

    task automatic test_no_sink_stall();
        sink_stall_en = 1'b0;
        for (int k = 0; k < 40; k++)
            send_word({4'($urandom_range(0, 6)), 12'($urandom)});
        sink_stall_en = 1'b1;
    endtask

    initial begin
        clear_vm();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_each_opcode();
        test_divide_by_zero();
        test_no_sink_stall();
        test_random_programs();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("sent %0d instruction words, checked %0d results", words_sent, results_seen);
        $display("programs ended by done: %0d, by error: %0d", done_seen, err_seen);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     pending_results.size());
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

// File: sim.f
+incdir+sv
sv/rvm_pkg.sv
sv/rvm_if.sv
sv/rvm_front.sv
sv/rvm_divider.sv
sv/rvm_back.sv
sv/register_vm_instruction_executor_core.sv
sv/rvm_checker.sv
bench/register_vm_instruction_executor_core_tb.sv
